// ===== rtl/streamout_buffer_binder_assert.svh =====
// Assertion macros for the streamout binder
`ifndef STREAMOUT_BUFFER_BINDER_ASSERT_SVH
`define STREAMOUT_BUFFER_BINDER_ASSERT_SVH

// clocked check, held off while reset is asserted
`define SOB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define SOB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/sob_pkg.sv =====
package sob_pkg;

  localparam int unsigned DIV_W = 17;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_DRAW    = 2'd1;
  localparam logic [1:0] OP_NO_DRAW = 2'd2;
  localparam logic [1:0] OP_FINISH  = 2'd3;

  localparam logic [2:0] KIND_BIND   = 3'd0;
  localparam logic [2:0] KIND_BEGIN  = 3'd1;
  localparam logic [2:0] KIND_COPY   = 3'd2;
  localparam logic [2:0] KIND_FINISH = 3'd3;
  localparam logic [2:0] KIND_ACK    = 3'd4;

  localparam logic CFG_RING_CAP   = 1'b0;
  localparam logic CFG_RING_RESET = 1'b1;

  localparam logic [30:0] RING_CAP_RESET = 31'd8388608;
  localparam logic [31:0] PAD_ADD        = 32'd255;
  localparam logic [31:0] PAD_MASK       = ~32'd255;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  buffer_select;
    logic [29:0] stride_dwords;
    logic [29:0] size_dwords;
    logic [23:0] base_blocks;
    logic [31:0] start_offset;
    logic [31:0] vertex_count;
    logic [31:0] instance_count;
    logic        gs_present;
    logic [29:0] gs_vertex_dwords;
    logic [14:0] gs_ring_dwords;
    logic [3:0]  write_mask;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  buffer_index;
    logic [30:0] ring_offset;
    logic [31:0] range_addr;
    logic [31:0] range_size;
    logic [31:0] new_offset;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [DIV_W-1:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MUL_V, S_MUL_LO, S_MUL_HI, S_SUM, S_BUF_MUL, S_BUF_RNG,
    S_BUF_EMIT, S_BEGIN, S_FIN, S_FIN_EMIT, S_ACK
  } state_e;

endpackage

// ===== rtl/sob_div.sv =====
module sob_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sob_pkg::div_req_t     req_i,
  output logic                  done_o,
  output logic [sob_pkg::DIV_W-1:0] quot_o
);
  import sob_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [4:0]       step_q;
  logic [17:0]      rem_q;
  logic [DIV_W-1:0] quot_q;
  logic [31:0]      dsr_q;
  logic [17:0]      trial;
  logic             ge;

  // one quotient bit a cycle, restoring
  assign trial = {rem_q[16:0], quot_q[DIV_W-1]};
  assign ge    = {14'd0, trial} >= dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quot_q <= req_i.dividend;
      dsr_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= ge ? (trial - dsr_q[17:0]) : trial;
      quot_q <= {quot_q[DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/streamout_buffer_binder.sv =====
// Channel | Direction | Transaction
// cfg     | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
// in      | in        | in_valid_i / in_ready_o, in_data_i
// out     | out       | out_valid_o / out_ready_i, out_data_o
//
// One item at a time; ready only while idle. Register writes, no-draw commands and idle
// finishes go straight to their acknowledge result. A streamout draw runs the divider
// (with a geometry shader), then the vertex and instance multiplies and their sum, then
// walks the buffers on the single shared 32x32 multiplier (multiply, range and bind for a
// written buffer, multiply only for a skipped one), closes the walk and emits begin. Finish
// walks the buffers, closes the walk and emits the finish result. Asynchronous active-low
// reset; no clearing pass. A stalled output holds the sequencer at its next emitting step.
module streamout_buffer_binder #(
  parameter int unsigned NUM_BUFFERS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [30:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sob_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sob_pkg::out_t  out_data_o
);
  import sob_pkg::*;

  localparam int unsigned IdxW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

  state_e state_q, state_d;

  logic [30:0] ring_cap_q;
  logic        ring_reset_q;
  logic [30:0] ring_pos_q;
  logic [30:0] remcap_q;
  logic [3:0]  active_q;
  logic        fb_active_q;
  logic [3:0]  cnt_q;

  logic [29:0] buf_stride_q [NUM_BUFFERS];
  logic [29:0] buf_size_q   [NUM_BUFFERS];
  logic [23:0] buf_base_q   [NUM_BUFFERS];
  logic [31:0] buf_off_q    [NUM_BUFFERS];
  logic [30:0] bnd_roff_q   [NUM_BUFFERS];
  logic [31:0] bnd_addr_q   [NUM_BUFFERS];
  logic [31:0] bnd_size_q   [NUM_BUFFERS];

  in_t         cmd_q;
  logic [DIV_W-1:0] budget_q;
  logic [48:0] verts_q;
  logic [63:0] p0_q;
  logic [48:0] p1_q;
  logic [63:0] written_q;
  logic [63:0] wprod_q;
  logic [30:0] range_q;

  logic        out_valid_q;
  out_t        out_q;

  div_req_t    div_req;
  logic        div_done;
  logic [DIV_W-1:0] div_quot;

  logic        acc;
  logic        out_free;
  logic        at_end;
  logic        sel_draw;
  logic        sel_fin;
  logic        need_copy;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] wsel;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        emit;
  out_t        emit_data;

  logic [31:0] stride_b, size_b, off, wr, remain, r1, r2;
  logic [31:0] alloc0, alloc, rng;
  logic [32:0] pos_sum;
  logic [30:0] at;
  logic [31:0] addr;
  logic [31:0] noff;
  logic [32:0] mid;
  logic        ovf;
  logic [31:0] bpv;

  sob_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign acc      = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign at_end   = cnt_q == 4'(NUM_BUFFERS);
  assign idx      = cnt_q[IdxW-1:0];
  assign wsel     = IdxW'({2'b00, in_data_i.buffer_select});
  assign sel_draw = (cnt_q < 4'd4) && cmd_q.write_mask[cnt_q[1:0]];
  assign sel_fin  = (cnt_q < 4'd4) && active_q[cnt_q[1:0]];
  assign need_copy = sel_fin && (bnd_size_q[idx] != '0);
  assign prod     = mul_a * mul_b;
  assign bpv      = {in_data_i.gs_vertex_dwords, 2'b00};

  // per-buffer datapath
  always_comb begin
    stride_b = {buf_stride_q[idx], 2'b00};
    size_b   = {buf_size_q[idx], 2'b00};
    off      = buf_off_q[idx];
    if (stride_b == '0 || written_q == '0) begin
      wr = '0;
    end else if ((|written_q[63:32]) || (wprod_q > {32'd0, size_b})) begin
      wr = size_b;
    end else begin
      wr = wprod_q[31:0];
    end
    remain = (off >= size_b) ? 32'd0 : (size_b - off);
    r1 = (wr > remain) ? remain : wr;
    r2 = (r1 > {1'b0, remcap_q}) ? {1'b0, remcap_q} : r1;
    alloc0 = ({1'b0, range_q} + PAD_ADD) & PAD_MASK;
    if (alloc0 > {1'b0, remcap_q}) begin
      rng   = {1'b0, remcap_q} & PAD_MASK;
      alloc = rng;
    end else begin
      rng   = {1'b0, range_q};
      alloc = alloc0;
    end
    pos_sum = {2'b00, ring_pos_q} + {1'b0, alloc};
    at      = (pos_sum > {2'b00, ring_cap_q}) ? 31'd0 : ring_pos_q;
    addr    = {buf_base_q[idx], 8'd0} + off;
    noff    = off + bnd_size_q[idx];
    mid     = {1'b0, p0_q[63:32]} + {1'b0, p1_q[31:0]};
    ovf     = (|p1_q[48:32]) || mid[32];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_data_i.op)
            OP_DRAW:   state_d = in_data_i.gs_present ? S_DIV : S_MUL_V;
            OP_FINISH: state_d = fb_active_q ? S_FIN : S_ACK;
            default:   state_d = S_ACK;
          endcase
        end
      end
      S_DIV:      if (div_done) state_d = S_MUL_V;
      S_MUL_V:    state_d = S_MUL_LO;
      S_MUL_LO:   state_d = S_MUL_HI;
      S_MUL_HI:   state_d = S_SUM;
      S_SUM:      state_d = S_BUF_MUL;
      S_BUF_MUL: begin
        if (at_end) begin
          state_d = S_BEGIN;
        end else if (sel_draw) begin
          state_d = S_BUF_RNG;
        end
      end
      S_BUF_RNG:  state_d = S_BUF_EMIT;
      S_BUF_EMIT: if (out_free) state_d = S_BUF_MUL;
      S_FIN:      if (at_end) state_d = S_FIN_EMIT;
      S_BEGIN, S_FIN_EMIT, S_ACK: begin
        if (out_free) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    emit       = 1'b0;
    emit_data  = '0;
    div_req.start    = 1'b0;
    div_req.dividend = {in_data_i.gs_ring_dwords, 2'b00};
    div_req.divisor  = (bpv == '0) ? 32'd1 : bpv;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        div_req.start = in_valid_i && (in_data_i.op == OP_DRAW) && in_data_i.gs_present;
      end
      S_MUL_V: begin
        mul_a = cmd_q.vertex_count;
        mul_b = 32'(budget_q);
      end
      S_MUL_LO: begin
        mul_a = verts_q[31:0];
        mul_b = cmd_q.instance_count;
      end
      S_MUL_HI: begin
        mul_a = 32'(verts_q[48:32]);
        mul_b = cmd_q.instance_count;
      end
      S_BUF_MUL: begin
        mul_a = written_q[31:0];
        mul_b = {buf_stride_q[idx], 2'b00};
      end
      S_BUF_EMIT: begin
        emit = out_free;
        emit_data.kind         = KIND_BIND;
        emit_data.buffer_index = cnt_q[1:0];
        emit_data.ring_offset  = at;
        emit_data.range_addr   = addr;
        emit_data.range_size   = rng;
      end
      S_FIN: begin
        emit = !at_end && need_copy && out_free;
        emit_data.kind         = KIND_COPY;
        emit_data.buffer_index = cnt_q[1:0];
        emit_data.ring_offset  = bnd_roff_q[idx];
        emit_data.range_addr   = bnd_addr_q[idx];
        emit_data.range_size   = bnd_size_q[idx];
        emit_data.new_offset   = noff;
      end
      S_BEGIN: begin
        emit = out_free;
        emit_data.kind = KIND_BEGIN;
        emit_data.last = 1'b1;
      end
      S_FIN_EMIT: begin
        emit = out_free;
        emit_data.kind = KIND_FINISH;
        emit_data.last = 1'b1;
      end
      S_ACK: begin
        emit = out_free;
        emit_data.kind = KIND_ACK;
        emit_data.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ring_cap_q   <= RING_CAP_RESET;
      ring_reset_q <= 1'b0;
      ring_pos_q   <= '0;
      active_q     <= '0;
      fb_active_q  <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        buf_stride_q[i] <= '0;
        buf_size_q[i]   <= '0;
        buf_base_q[i]   <= '0;
        buf_off_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RING_CAP:   ring_cap_q   <= cfg_wdata_i;
          CFG_RING_RESET: ring_reset_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            case (in_data_i.op)
              OP_WRITE: begin
                if (32'(in_data_i.buffer_select) < NUM_BUFFERS) begin
                  buf_stride_q[wsel] <= in_data_i.stride_dwords;
                  buf_size_q[wsel]   <= in_data_i.size_dwords;
                  buf_base_q[wsel]   <= in_data_i.base_blocks;
                  buf_off_q[wsel]    <= in_data_i.start_offset;
                end
              end
              OP_DRAW: begin
                if (ring_reset_q) ring_pos_q <= '0;
                active_q    <= '0;
                fb_active_q <= 1'b1;
              end
              OP_NO_DRAW: fb_active_q <= 1'b0;
              default: begin
                fb_active_q <= 1'b0;
                cnt_q       <= '0;
              end
            endcase
          end
        end
        S_SUM: cnt_q <= '0;
        S_BUF_MUL: if (!at_end && !sel_draw) cnt_q <= cnt_q + 4'd1;
        S_BUF_EMIT: begin
          if (out_free) begin
            ring_pos_q <= 31'(pos_sum - {2'b00, ring_pos_q} + {2'b00, at});
            active_q[cnt_q[1:0]] <= 1'b1;
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_FIN: begin
          // wait only when a copy is due and the output is still full
          if (!at_end && !(need_copy && !out_free)) begin
            if (sel_fin) buf_off_q[idx] <= noff;
            cnt_q <= cnt_q + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) cmd_q <= in_data_i;
    if (emit) out_q <= emit_data;
    case (state_q)
      S_IDLE:   if (acc) budget_q <= DIV_W'(1);
      S_DIV:    if (div_done) budget_q <= (div_quot == '0) ? DIV_W'(1) : div_quot;
      S_MUL_V:  verts_q <= prod[48:0];
      S_MUL_LO: p0_q <= prod;
      S_MUL_HI: p1_q <= prod[48:0];
      S_SUM: begin
        written_q <= ovf ? '1 : {mid[31:0], p0_q[31:0]};
        remcap_q  <= ring_cap_q;
      end
      S_BUF_MUL: wprod_q <= prod;
      S_BUF_RNG: range_q <= r2[30:0];
      S_BUF_EMIT: begin
        if (out_free) begin
          remcap_q        <= remcap_q - alloc[30:0];
          bnd_roff_q[idx] <= at;
          bnd_addr_q[idx] <= addr;
          bnd_size_q[idx] <= rng;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "streamout_buffer_binder_assert.svh"

  `SOB_ASSERT(a_busy_after_accept, acc |=> !in_ready_o, "block still ready after accepting an item")
  `SOB_ASSERT(a_bind_aligned, (out_valid_o && out_data_o.kind == KIND_BIND) |-> (out_data_o.ring_offset[7:0] == 8'd0), "ring offset of a bind not 256-byte aligned")
  `SOB_ASSERT(a_last_kind, (out_valid_o && out_data_o.last) |-> (out_data_o.kind != KIND_BIND && out_data_o.kind != KIND_COPY), "bind or copy flagged as last result")

endmodule
